### src/mof_pkg.sv
// ============================================================================
// mof_pkg: shared types and constants for the MessagePack object framer
// Phase and length-target codes, format byte decode record, result record.
// ============================================================================
package mof_pkg;

    // Default widths of the pending-object counter and the group byte counter
    localparam int PENDING_WIDTH_DEF = 40;
    localparam int TOTAL_WIDTH_DEF   = 48;

    // Fixed field widths
    localparam int BYTES_W  = 48;   // group_bytes as shown on the port
    localparam int CFG_W    = 16;   // objects_per_group
    localparam int ACC_W    = 32;   // collected length/count field
    localparam int PAY_W    = ACC_W + 1;  // payload bytes left (ext adds its type byte)
    localparam int ADD_W    = ACC_W + 1;  // children added (a map doubles its count)
    localparam int LEFT_W   = 3;    // length field bytes left
    localparam int CNT_W    = 5;    // small count or size from a format byte

    // Decoder phase
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // What a collected length field means
    localparam logic [1:0] TGT_PAYLOAD = 2'd0;
    localparam logic [1:0] TGT_EXT     = 2'd1;
    localparam logic [1:0] TGT_ARRAY   = 2'd2;
    localparam logic [1:0] TGT_MAP     = 2'd3;

    // Format byte classes
    localparam logic [2:0] HK_LEAF    = 3'd0;
    localparam logic [2:0] HK_ADD     = 3'd1;
    localparam logic [2:0] HK_PAYLOAD = 3'd2;
    localparam logic [2:0] HK_LENGTH  = 3'd3;
    localparam logic [2:0] HK_BAD     = 3'd4;

    typedef struct packed {
        logic [2:0]        kind;
        logic [CNT_W-1:0]  cnt;        // children to add, or payload bytes
        logic [LEFT_W-1:0] len_bytes;  // size of the following length field
        logic [1:0]        target;
    } hdr_dec_t;

    typedef struct packed {
        logic               group_end;
        logic [BYTES_W-1:0] group_bytes;
        logic               format_error;
    } mof_result_t;

endpackage

### src/mof_hdr_dec.sv
// ============================================================================
// mof_hdr_dec: MessagePack format byte decoder
// Classifies one format byte: leaf, container, fixed payload, length or bad.
// ============================================================================
module mof_hdr_dec (
    input  logic [7:0]        data_byte,
    output mof_pkg::hdr_dec_t dec
);
    import mof_pkg::*;

    always_comb
    begin
        dec           = '0;
        dec.kind      = HK_LEAF;
        if (data_byte <= 8'h7f || data_byte >= 8'he0)
        begin
            dec.kind = HK_LEAF;
        end
        else if (data_byte <= 8'h8f)
        begin
            // fixmap: two objects per entry
            dec.kind = HK_ADD;
            dec.cnt  = {data_byte[3:0], 1'b0};
        end
        else if (data_byte <= 8'h9f)
        begin
            dec.kind = HK_ADD;
            dec.cnt  = {1'b0, data_byte[3:0]};
        end
        else if (data_byte <= 8'hbf)
        begin
            dec.kind = HK_PAYLOAD;
            dec.cnt  = data_byte[4:0];
        end
        else
        begin
            case (data_byte)
                8'hc1:
                begin
                    dec.kind = HK_BAD;
                end
                8'hc4, 8'hd9:
                begin
                    dec.kind = HK_LENGTH; dec.len_bytes = 3'd1; dec.target = TGT_PAYLOAD;
                end
                8'hc5, 8'hda:
                begin
                    dec.kind = HK_LENGTH; dec.len_bytes = 3'd2; dec.target = TGT_PAYLOAD;
                end
                8'hc6, 8'hdb:
                begin
                    dec.kind = HK_LENGTH; dec.len_bytes = 3'd4; dec.target = TGT_PAYLOAD;
                end
                8'hc7:
                begin
                    dec.kind = HK_LENGTH; dec.len_bytes = 3'd1; dec.target = TGT_EXT;
                end
                8'hc8:
                begin
                    dec.kind = HK_LENGTH; dec.len_bytes = 3'd2; dec.target = TGT_EXT;
                end
                8'hc9:
                begin
                    dec.kind = HK_LENGTH; dec.len_bytes = 3'd4; dec.target = TGT_EXT;
                end
                8'hdc:
                begin
                    dec.kind = HK_LENGTH; dec.len_bytes = 3'd2; dec.target = TGT_ARRAY;
                end
                8'hdd:
                begin
                    dec.kind = HK_LENGTH; dec.len_bytes = 3'd4; dec.target = TGT_ARRAY;
                end
                8'hde:
                begin
                    dec.kind = HK_LENGTH; dec.len_bytes = 3'd2; dec.target = TGT_MAP;
                end
                8'hdf:
                begin
                    dec.kind = HK_LENGTH; dec.len_bytes = 3'd4; dec.target = TGT_MAP;
                end
                8'hcc, 8'hd0:
                begin
                    dec.kind = HK_PAYLOAD; dec.cnt = 5'd1;
                end
                8'hcd, 8'hd1, 8'hd4:
                begin
                    dec.kind = HK_PAYLOAD; dec.cnt = 5'd2;
                end
                8'hd5:
                begin
                    dec.kind = HK_PAYLOAD; dec.cnt = 5'd3;
                end
                8'hca, 8'hce, 8'hd2:
                begin
                    dec.kind = HK_PAYLOAD; dec.cnt = 5'd4;
                end
                8'hd6:
                begin
                    // fixext 4: type byte plus data
                    dec.kind = HK_PAYLOAD; dec.cnt = 5'd5;
                end
                8'hcb, 8'hcf, 8'hd3:
                begin
                    dec.kind = HK_PAYLOAD; dec.cnt = 5'd8;
                end
                8'hd7:
                begin
                    dec.kind = HK_PAYLOAD; dec.cnt = 5'd9;
                end
                8'hd8:
                begin
                    dec.kind = HK_PAYLOAD; dec.cnt = 5'd17;
                end
                default:
                begin
                    // nil, false, true
                    dec.kind = HK_LEAF;
                end
            endcase
        end
    end

endmodule

### src/mof_core.sv
// ============================================================================
// mof_core: framing state and single-pass next-state logic
// Holds phase, counters and group tally; computes one byte's result.
// ============================================================================
module mof_core #(
    parameter int PENDING_WIDTH = mof_pkg::PENDING_WIDTH_DEF,
    parameter int TOTAL_WIDTH   = mof_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [7:0]                 data_byte,
    input  logic [mof_pkg::CFG_W-1:0]  objects_per_group,
    output mof_pkg::mof_result_t       result
);
    import mof_pkg::*;

    localparam int SUM_W = PENDING_WIDTH + 1;

    logic [1:0]               phase_reg,    phase_next;
    logic [PENDING_WIDTH-1:0] pend_reg,     pend_next;
    logic [ACC_W-1:0]         acc_reg,      acc_next;
    logic [LEFT_W-1:0]        len_left_reg, len_left_next;
    logic [1:0]               target_reg,   target_next;
    logic [PAY_W-1:0]         pay_left_reg, pay_left_next;
    logic [TOTAL_WIDTH-1:0]   total_reg,    total_next;
    logic [CFG_W-1:0]         objs_reg,     objs_next;

    hdr_dec_t dec;

    mof_hdr_dec u_hdr_dec (
        .data_byte (data_byte),
        .dec       (dec)
    );

    logic [TOTAL_WIDTH-1:0]   total_inc;
    logic [PENDING_WIDTH-1:0] pend_dec;
    logic [PENDING_WIDTH-1:0] pend_base;
    logic [PENDING_WIDTH-1:0] pend_sat;
    logic [SUM_W-1:0]         pend_sum;
    logic [ACC_W-1:0]         acc_new;
    logic                     add_en;
    logic [ADD_W-1:0]         add_cnt;
    logic                     pay_en;
    logic [PAY_W-1:0]         pay_n;
    logic                     top_done;
    logic                     bad;
    logic [CFG_W:0]           obj_inc;
    logic [CFG_W-1:0]         need;

    assign total_inc = (&total_reg) ? total_reg : total_reg + TOTAL_WIDTH'(1);
    assign pend_dec  = (pend_reg != '0) ? pend_reg - PENDING_WIDTH'(1) : pend_reg;
    assign acc_new   = {acc_reg[ACC_W-9:0], data_byte};
    assign need      = (objects_per_group == '0) ? CFG_W'(1) : objects_per_group;
    assign obj_inc   = {1'b0, objs_reg} + (CFG_W+1)'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        pend_next     = pend_reg;
        acc_next      = acc_reg;
        len_left_next = len_left_reg;
        target_next   = target_reg;
        pay_left_next = pay_left_reg;
        total_next    = total_inc;
        objs_next     = objs_reg;
        pend_base     = pend_reg;
        add_en        = 1'b0;
        add_cnt       = '0;
        pay_en        = 1'b0;
        pay_n         = '0;
        top_done      = 1'b0;
        bad           = 1'b0;

        case (phase_reg)
            PH_LENGTH:
            begin
                acc_next = acc_new;
                if (len_left_reg <= LEFT_W'(1))
                begin
                    len_left_next = '0;
                    phase_next    = PH_HEADER;
                    case (target_reg)
                        TGT_PAYLOAD:
                        begin
                            pay_en = 1'b1;
                            pay_n  = {1'b0, acc_new};
                        end
                        TGT_EXT:
                        begin
                            // ext type byte is skipped with the data
                            pay_en = 1'b1;
                            pay_n  = {1'b0, acc_new} + PAY_W'(1);
                        end
                        TGT_ARRAY:
                        begin
                            add_en  = 1'b1;
                            add_cnt = {1'b0, acc_new};
                        end
                        default:
                        begin
                            add_en  = 1'b1;
                            add_cnt = {acc_new, 1'b0};
                        end
                    endcase
                end
                else
                begin
                    len_left_next = len_left_reg - LEFT_W'(1);
                end
            end
            PH_PAYLOAD:
            begin
                if (pay_left_reg <= PAY_W'(1))
                begin
                    pay_left_next = '0;
                    phase_next    = PH_HEADER;
                    top_done      = (pend_reg == '0);
                end
                else
                begin
                    pay_left_next = pay_left_reg - PAY_W'(1);
                end
            end
            default:
            begin
                // format byte: it fills one owed slot first
                pend_base = pend_dec;
                pend_next = pend_dec;
                case (dec.kind)
                    HK_ADD:
                    begin
                        add_en  = 1'b1;
                        add_cnt = ADD_W'(dec.cnt);
                    end
                    HK_PAYLOAD:
                    begin
                        pay_en = 1'b1;
                        pay_n  = PAY_W'(dec.cnt);
                    end
                    HK_LENGTH:
                    begin
                        acc_next      = '0;
                        len_left_next = dec.len_bytes;
                        target_next   = dec.target;
                        phase_next    = PH_LENGTH;
                    end
                    HK_BAD:
                    begin
                        bad = 1'b1;
                    end
                    default:
                    begin
                        top_done = (pend_dec == '0);
                    end
                endcase
            end
        endcase

        pend_sum = {1'b0, pend_base} + SUM_W'(add_cnt);
        pend_sat = pend_sum[PENDING_WIDTH] ? '1 : pend_sum[PENDING_WIDTH-1:0];

        if (add_en)
        begin
            pend_next = pend_sat;
            top_done  = (pend_sat == '0);
        end

        if (pay_en)
        begin
            if (pay_n == '0)
            begin
                top_done = (pend_base == '0);
            end
            else
            begin
                pay_left_next = pay_n;
                phase_next    = PH_PAYLOAD;
            end
        end

        result              = '0;
        result.group_bytes  = BYTES_W'(total_inc);

        if (bad)
        begin
            // drop the group and restart at a format byte
            phase_next          = PH_HEADER;
            pend_next           = '0;
            total_next          = '0;
            objs_next           = '0;
            result.group_bytes  = '0;
            result.format_error = 1'b1;
        end
        else if (top_done)
        begin
            if (obj_inc >= {1'b0, need})
            begin
                result.group_end = 1'b1;
                total_next       = '0;
                objs_next        = '0;
            end
            else
            begin
                objs_next = obj_inc[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pend_reg     <= '0;
            acc_reg      <= '0;
            len_left_reg <= '0;
            target_reg   <= TGT_PAYLOAD;
            pay_left_reg <= '0;
            total_reg    <= '0;
            objs_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            pend_reg     <= pend_next;
            acc_reg      <= acc_next;
            len_left_reg <= len_left_next;
            target_reg   <= target_next;
            pay_left_reg <= pay_left_next;
            total_reg    <= total_next;
            objs_reg     <= objs_next;
        end
    end

endmodule

### src/msgpack_object_framer.sv
// ============================================================================
// msgpack_object_framer: MessagePack top-level object framer
// Stream in bytes, stream out one result beat per byte with group boundaries.
// ============================================================================
// Every input beat carries one byte of a MessagePack stream and produces
// exactly one output beat, in order. The block decodes format bytes, gathers
// big-endian length and count fields, skips payload (ext type byte included)
// and tracks nesting as a single count of objects still owed. When
// objects_per_group top-level objects have completed (0 behaves as 1), the
// beat for the closing byte has tlast set and tdata holds the group size in
// bytes, saturating. Other beats show the running size. A format byte 0xc1
// raises tuser, reports size 0 and drops the group in progress. Throughput is
// one byte per clock when the output is not stalled: each byte passes an
// input register, one pass of decode and counter update logic, and an
// output register. The result beat is offered from the output register once
// the byte has passed the input register and the decode logic. Both
// registers hold under backpressure and a new byte is taken in the same
// cycle the previous one advances. cfg_data is always accepted; write it
// only while the block is idle (all results delivered). It resets to 1.
module msgpack_object_framer #(
    parameter int PENDING_WIDTH = mof_pkg::PENDING_WIDTH_DEF,
    parameter int TOTAL_WIDTH   = mof_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,    // [7:0] data_byte
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [mof_pkg::BYTES_W-1:0] m_tdata,  // [47:0] group_bytes
    output logic                      m_tlast,    // group_end
    output logic                      m_tuser,    // [0] format_error
    // objects_per_group write
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [mof_pkg::CFG_W-1:0] cfg_data
);
    import mof_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    mof_result_t       out_res_reg;
    logic [CFG_W-1:0]  opg_reg;
    logic              advance;
    mof_result_t       result;

    // byte moves from input register to output register this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.group_bytes;
    assign m_tlast  = out_res_reg.group_end;
    assign m_tuser  = out_res_reg.format_error;

    assign cfg_ready = 1'b1;

    mof_core #(
        .PENDING_WIDTH (PENDING_WIDTH),
        .TOTAL_WIDTH   (TOTAL_WIDTH)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (advance),
        .data_byte         (in_byte_reg),
        .objects_per_group (opg_reg),
        .result            (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            opg_reg       <= CFG_W'(1);
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                opg_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_res_reg <= result;
        end
    end

endmodule

### tb/msgpack_object_framer_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// msgpack_object_framer_tb: self-checking bench for the MessagePack framer
// Streams MessagePack bytes into the framer through a randomly stalling
// driver. A cycle-free copy of the framing rules predicts one result beat per
// byte. A monitor with random backpressure compares each result beat field by
// field. Group size is changed between traffic phases, only while drained.
// ============================================================================
module msgpack_object_framer_tb;

    import mof_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int PEND_W = PENDING_WIDTH_DEF;
    localparam int TOT_W  = TOTAL_WIDTH_DEF;
    localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};
    localparam logic [TOT_W-1:0]  TOT_MAX  = {TOT_W{1'b1}};

    localparam int DRAIN_CYCLES = 4;     // two-stage pipe plus margin
    localparam int STALL_LIMIT  = 2000;  // cycles with no beat on any channel
    localparam int HOLD_AT      = 200;   // result count that starts the long hold
    localparam int HOLD_CYCLES  = 400;   // length of the long receiver hold
    localparam int MAX_SHOWN    = 100;   // mismatch lines printed at most

    // MessagePack format bytes
    localparam logic [7:0] POSFIX_MAX   = 8'h7f;
    localparam logic [7:0] FMT_FIXMAP   = 8'h80;
    localparam logic [7:0] FMT_FIXARRAY = 8'h90;
    localparam logic [7:0] FMT_FIXSTR   = 8'ha0;
    localparam logic [7:0] FMT_NIL      = 8'hc0;
    localparam logic [7:0] FMT_UNUSED   = 8'hc1;
    localparam logic [7:0] FMT_FALSE    = 8'hc2;
    localparam logic [7:0] FMT_TRUE     = 8'hc3;
    localparam logic [7:0] FMT_BIN8     = 8'hc4;
    localparam logic [7:0] FMT_BIN16    = 8'hc5;
    localparam logic [7:0] FMT_BIN32    = 8'hc6;
    localparam logic [7:0] FMT_EXT8     = 8'hc7;
    localparam logic [7:0] FMT_EXT16    = 8'hc8;
    localparam logic [7:0] FMT_EXT32    = 8'hc9;
    localparam logic [7:0] FMT_FLOAT32  = 8'hca;
    localparam logic [7:0] FMT_FLOAT64  = 8'hcb;
    localparam logic [7:0] FMT_UINT8    = 8'hcc;
    localparam logic [7:0] FMT_UINT16   = 8'hcd;
    localparam logic [7:0] FMT_UINT32   = 8'hce;
    localparam logic [7:0] FMT_UINT64   = 8'hcf;
    localparam logic [7:0] FMT_INT8     = 8'hd0;
    localparam logic [7:0] FMT_INT16    = 8'hd1;
    localparam logic [7:0] FMT_INT32    = 8'hd2;
    localparam logic [7:0] FMT_INT64    = 8'hd3;
    localparam logic [7:0] FMT_FIXEXT1  = 8'hd4;
    localparam logic [7:0] FMT_FIXEXT2  = 8'hd5;
    localparam logic [7:0] FMT_FIXEXT4  = 8'hd6;
    localparam logic [7:0] FMT_FIXEXT8  = 8'hd7;
    localparam logic [7:0] FMT_FIXEXT16 = 8'hd8;
    localparam logic [7:0] FMT_STR8     = 8'hd9;
    localparam logic [7:0] FMT_STR16    = 8'hda;
    localparam logic [7:0] FMT_STR32    = 8'hdb;
    localparam logic [7:0] FMT_ARRAY16  = 8'hdc;
    localparam logic [7:0] FMT_ARRAY32  = 8'hdd;
    localparam logic [7:0] FMT_MAP16    = 8'hde;
    localparam logic [7:0] FMT_MAP32    = 8'hdf;
    localparam logic [7:0] FMT_NEGFIX   = 8'he0;

    // Opening sequence: byte extremes, scalars, an empty map, array and string,
    // a small map, an unused code between objects, a short array, bin8 with no
    // payload, ext8 with only its type byte, and an unused code inside an array.
    localparam logic [7:0] OPENING [26] = '{
        8'h00, 8'hff, FMT_NIL, FMT_FALSE, FMT_TRUE,
        FMT_FIXMAP, FMT_FIXARRAY, FMT_FIXSTR,
        FMT_FIXMAP | 8'h01, 8'h01, 8'h02,
        FMT_UNUSED,
        FMT_FIXARRAY | 8'h02, FMT_UINT8, 8'hff, FMT_FIXSTR | 8'h01, 8'h41,
        FMT_BIN8, 8'h00,
        FMT_EXT8, 8'h00, 8'h05,
        FMT_FIXARRAY | 8'h01, FMT_UNUSED,
        POSFIX_MAX, FMT_NEGFIX
    };

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = 8'h00;   // [7:0] data_byte
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [BYTES_W-1:0] m_tdata;             // [47:0] group_bytes
    logic               m_tlast;             // group_end
    logic               m_tuser;             // [0] format_error
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data  = '0;

    msgpack_object_framer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Framing predictor state (mirrors the block's registers)
    // ------------------------------------------------------------------------
    logic [1:0]        ph       = PH_HEADER;
    logic [PEND_W-1:0] owed     = '0;     // objects still owed to the top object
    logic [31:0]       len_acc  = '0;
    logic [2:0]        len_left = '0;
    logic [33:0]       pay_left = '0;
    logic [1:0]        len_tgt  = TGT_PAYLOAD;
    logic [TOT_W-1:0]  grp_total = '0;
    logic [16:0]       grp_objs = '0;
    logic [CFG_W-1:0]  grp_cfg  = 16'd1;  // objects_per_group, reset value

    mof_result_t group_results [$];       // predicted beats, oldest first
    logic [7:0]  stream_q [$];            // bytes not yet offered to the DUT
    logic [7:0]  obj_q [$];               // object under construction
    int          hdr_at [$];              // format byte positions within obj_q

    // Bookkeeping
    int bytes_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int groups_seen   = 0;
    int errors_seen   = 0;
    int cfg_writes    = 0;
    int owed_sat_hits = 0;
    int stall_cycles  = 0;
    bit no_idle       = 1'b0;             // set for the closing phase

    // Flow control state of driver and monitor
    int in_gap = 0, in_calm = 0;
    int out_gap = 0, out_calm = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // ------------------------------------------------------------------------
    // Predictor helpers
    // ------------------------------------------------------------------------
    // Add children to the owed count, saturating; 1 when the top object closes
    function automatic bit add_owed(input logic [33:0] n);
        logic [PEND_W:0] sum;
        sum = {1'b0, owed} + n;
        if (sum > {1'b0, PEND_MAX})
        begin
            owed = PEND_MAX;
            owed_sat_hits++;
        end
        else
            owed = sum[PEND_W-1:0];
        return owed == '0;
    endfunction

    function automatic bit leaf_end();
        ph = PH_HEADER;
        return owed == '0;
    endfunction

    function automatic bit start_pay(input logic [33:0] n);
        if (n == '0)
            return leaf_end();
        pay_left = n;
        ph       = PH_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic void start_len(input logic [2:0] nbytes, input logic [1:0] tgt);
        len_acc  = '0;
        len_left = nbytes;
        len_tgt  = tgt;
        ph       = PH_LENGTH;
    endfunction

    // One accepted byte in, one predicted result beat out
    task automatic frame_byte(input logic [7:0] b);
        bit          top;
        bit          bad;
        logic [16:0] need;
        mof_result_t res;
        top = 1'b0;
        bad = 1'b0;
        if (grp_total != TOT_MAX)
            grp_total++;
        case (ph)
            PH_LENGTH:
            begin
                len_acc = {len_acc[23:0], b};
                if (len_left <= 3'd1)
                begin
                    len_left = '0;
                    ph       = PH_HEADER;
                    case (len_tgt)
                        TGT_PAYLOAD: top = start_pay({2'b00, len_acc});
                        TGT_EXT:     top = start_pay({2'b00, len_acc} + 34'd1);  // type byte
                        TGT_ARRAY:   top = add_owed({2'b00, len_acc});
                        default:     top = add_owed({1'b0, len_acc, 1'b0});      // map: pairs
                    endcase
                end
                else
                    len_left--;
            end
            PH_PAYLOAD:
            begin
                if (pay_left <= 34'd1)
                begin
                    pay_left = '0;
                    top      = leaf_end();
                end
                else
                    pay_left--;
            end
            default:
            begin
                // the format byte itself is one of the owed objects
                if (owed != '0)
                    owed--;
                if (b <= POSFIX_MAX || b >= FMT_NEGFIX)
                    top = leaf_end();
                else if (b < FMT_FIXARRAY)
                    top = add_owed({b[3:0], 1'b0});
                else if (b < FMT_FIXSTR)
                    top = add_owed(b[3:0]);
                else if (b < FMT_NIL)
                    top = start_pay(b[4:0]);
                else
                    case (b)
                        FMT_UNUSED:                bad = 1'b1;
                        FMT_BIN8, FMT_STR8:        start_len(3'd1, TGT_PAYLOAD);
                        FMT_BIN16, FMT_STR16:      start_len(3'd2, TGT_PAYLOAD);
                        FMT_BIN32, FMT_STR32:      start_len(3'd4, TGT_PAYLOAD);
                        FMT_EXT8:                  start_len(3'd1, TGT_EXT);
                        FMT_EXT16:                 start_len(3'd2, TGT_EXT);
                        FMT_EXT32:                 start_len(3'd4, TGT_EXT);
                        FMT_ARRAY16:               start_len(3'd2, TGT_ARRAY);
                        FMT_ARRAY32:               start_len(3'd4, TGT_ARRAY);
                        FMT_MAP16:                 start_len(3'd2, TGT_MAP);
                        FMT_MAP32:                 start_len(3'd4, TGT_MAP);
                        FMT_UINT8, FMT_INT8:       top = start_pay(34'd1);
                        FMT_UINT16, FMT_INT16:     top = start_pay(34'd2);
                        FMT_FLOAT32, FMT_UINT32,
                        FMT_INT32:                 top = start_pay(34'd4);
                        FMT_FLOAT64, FMT_UINT64,
                        FMT_INT64:                 top = start_pay(34'd8);
                        FMT_FIXEXT1:               top = start_pay(34'd2);
                        FMT_FIXEXT2:               top = start_pay(34'd3);
                        FMT_FIXEXT4:               top = start_pay(34'd5);
                        FMT_FIXEXT8:               top = start_pay(34'd9);
                        FMT_FIXEXT16:              top = start_pay(34'd17);
                        default:                   top = leaf_end();  // nil, false, true
                    endcase
            end
        endcase

        res = '0;
        if (bad)
        begin
            // unused code drops the group in progress
            ph        = PH_HEADER;
            owed      = '0;
            grp_total = '0;
            grp_objs  = '0;
            res.format_error = 1'b1;
        end
        else
        begin
            res.group_bytes = grp_total[BYTES_W-1:0];
            if (top)
            begin
                need = (grp_cfg == '0) ? 17'd1 : {1'b0, grp_cfg};
                grp_objs++;
                if (grp_objs >= need)
                begin
                    res.group_end = 1'b1;
                    grp_total     = '0;
                    grp_objs      = '0;
                end
            end
        end
        group_results.push_back(res);
    endtask

    // ------------------------------------------------------------------------
    // Stream generation
    // ------------------------------------------------------------------------
    task automatic send(input logic [7:0] b);
        stream_q.push_back(b);
        bytes_sent++;
    endtask

    task automatic put_hdr(input logic [7:0] b);
        hdr_at.push_back(obj_q.size());
        obj_q.push_back(b);
    endtask

    task automatic put_rand(input int n);
        repeat (n) obj_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // big-endian length or count field
    task automatic put_len(input logic [31:0] n, input int nbytes);
        int i;
        for (i = nbytes - 1; i >= 0; i--)
            obj_q.push_back(n[8*i +: 8]);
    endtask

    // One well-formed object with random content; containers nest up to depth 3
    task automatic gen_obj(input int depth);
        int         sel;
        int         n;
        int         k;
        int         w;
        logic [7:0] code;
        sel = (depth >= 3) ? $urandom_range(0, 8) : $urandom_range(0, 12);
        case (sel)
            0: put_hdr(8'($urandom_range(0, POSFIX_MAX)));
            1: put_hdr(8'($urandom_range(FMT_NEGFIX, 8'hff)));
            2:
            begin
                k = $urandom_range(0, 2);
                put_hdr(k == 0 ? FMT_NIL : (k == 1 ? FMT_FALSE : FMT_TRUE));
            end
            3:
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
                put_hdr(FMT_FIXSTR | 8'(n));
                put_rand(n);
            end
            4:
            begin
                case ($urandom_range(0, 9))
                    0:       begin code = FMT_UINT8;   n = 1; end
                    1:       begin code = FMT_INT8;    n = 1; end
                    2:       begin code = FMT_UINT16;  n = 2; end
                    3:       begin code = FMT_INT16;   n = 2; end
                    4:       begin code = FMT_UINT32;  n = 4; end
                    5:       begin code = FMT_INT32;   n = 4; end
                    6:       begin code = FMT_FLOAT32; n = 4; end
                    7:       begin code = FMT_UINT64;  n = 8; end
                    8:       begin code = FMT_INT64;   n = 8; end
                    default: begin code = FMT_FLOAT64; n = 8; end
                endcase
                put_hdr(code);
                put_rand(n);
            end
            5:
            begin
                case ($urandom_range(0, 4))
                    0:       begin code = FMT_FIXEXT1;  n = 2;  end
                    1:       begin code = FMT_FIXEXT2;  n = 3;  end
                    2:       begin code = FMT_FIXEXT4;  n = 5;  end
                    3:       begin code = FMT_FIXEXT8;  n = 9;  end
                    default: begin code = FMT_FIXEXT16; n = 17; end
                endcase
                put_hdr(code);
                put_rand(n);
            end
            6:
            begin
                case ($urandom_range(0, 5))
                    0:       begin code = FMT_BIN8;  w = 1; end
                    1:       begin code = FMT_STR8;  w = 1; end
                    2:       begin code = FMT_BIN16; w = 2; end
                    3:       begin code = FMT_STR16; w = 2; end
                    4:       begin code = FMT_BIN32; w = 4; end
                    default: begin code = FMT_STR32; w = 4; end
                endcase
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
                put_hdr(code);
                put_len(n, w);
                put_rand(n);
            end
            7:
            begin
                case ($urandom_range(0, 2))
                    0:       begin code = FMT_EXT8;  w = 1; end
                    1:       begin code = FMT_EXT16; w = 2; end
                    default: begin code = FMT_EXT32; w = 4; end
                endcase
                n = $urandom_range(0, 6);
                put_hdr(code);
                put_len(n, w);
                put_rand(n + 1);  // type byte plus data
            end
            8:
            begin
                // empty containers
                case ($urandom_range(0, 5))
                    0:       put_hdr(FMT_FIXMAP);
                    1:       put_hdr(FMT_FIXARRAY);
                    2:       begin put_hdr(FMT_ARRAY16); put_len(0, 2); end
                    3:       begin put_hdr(FMT_ARRAY32); put_len(0, 4); end
                    4:       begin put_hdr(FMT_MAP16);   put_len(0, 2); end
                    default: begin put_hdr(FMT_MAP32);   put_len(0, 4); end
                endcase
            end
            9, 10:
            begin
                // arrays; now and then a full fixarray of leaves
                n = (depth == 0 && $urandom_range(0, 9) == 0) ? 15 : $urandom_range(1, 4);
                k = $urandom_range(0, 2);
                if (k == 0 || n == 15)
                    put_hdr(FMT_FIXARRAY | 8'(n));
                else if (k == 1)
                begin
                    put_hdr(FMT_ARRAY16);
                    put_len(n, 2);
                end
                else
                begin
                    put_hdr(FMT_ARRAY32);
                    put_len(n, 4);
                end
                repeat (n) gen_obj(n == 15 ? 3 : depth + 1);
            end
            default:
            begin
                n = $urandom_range(1, 3);
                k = $urandom_range(0, 2);
                if (k == 0)
                    put_hdr(FMT_FIXMAP | 8'(n));
                else if (k == 1)
                begin
                    put_hdr(FMT_MAP16);
                    put_len(n, 2);
                end
                else
                begin
                    put_hdr(FMT_MAP32);
                    put_len(n, 4);
                end
                repeat (2 * n) gen_obj(depth + 1);
            end
        endcase
    endtask

    // Mostly whole objects. Some are cut at a format byte and closed with the
    // unused code, so the framer resyncs cleanly. A few single noise bytes
    // stand between objects (never one that would swallow later bytes).
    task automatic queue_random(input int nbytes);
        int         goal;
        int         k;
        int         cut;
        logic [7:0] b;
        goal = bytes_sent + nbytes;
        while (bytes_sent < goal)
        begin
            k = $urandom_range(0, 19);
            if (k == 0)
            begin
                b = 8'($urandom_range(0, 255));
                if (!(b <= POSFIX_MAX || b == FMT_FIXMAP || b == FMT_FIXARRAY ||
                      b == FMT_FIXSTR || (b >= FMT_NIL && b <= FMT_TRUE) || b >= FMT_NEGFIX))
                    b = FMT_UNUSED;
                send(b);
            end
            else
            begin
                obj_q.delete();
                hdr_at.delete();
                gen_obj(0);
                if (k == 1)
                begin
                    cut = hdr_at[$urandom_range(0, hdr_at.size() - 1)];
                    while (obj_q.size() > cut)
                        obj_q.delete(obj_q.size() - 1);
                    obj_q.push_back(FMT_UNUSED);
                end
                foreach (obj_q[i])
                    send(obj_q[i]);
            end
        end
    endtask

    // Wait until every byte sent has produced its result beat
    task automatic drain();
        while (results_seen < bytes_sent)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Group size write; only called with the pipe empty
    task automatic set_group(input logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        grp_cfg = v;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued bytes, random idle bursts, holds a beat until taken
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                frame_byte(s_tdata);
            if (!s_tvalid || s_tready)
            begin
                // calm stretches: no idling for a while
                if (in_calm != 0)
                    in_calm--;
                else if (!no_idle && $urandom_range(0, 59) == 0)
                    in_calm = $urandom_range(20, 120);
                if (in_gap != 0)
                begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (!no_idle && in_calm == 0 && $urandom_range(0, 6) == 0)
                begin
                    in_gap = $urandom_range(0, 12);  // idle gap starts in this cycle
                    s_tvalid <= 1'b0;
                end
                else if (stream_q.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= stream_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result beat, drives backpressure
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        mof_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (m_tlast)
                    groups_seen++;
                if (m_tuser)
                    errors_seen++;
                if (group_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: unexpected result beat tdata=%h tlast=%b tuser=%b",
                                 $time, m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    want = group_results.pop_front();
                    if (m_tlast !== want.group_end)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("%0t: group_end expected %b actual %b",
                                     $time, want.group_end, m_tlast);
                    end
                    if (m_tdata !== want.group_bytes)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("%0t: group_bytes expected %0d actual %0d",
                                     $time, want.group_bytes, m_tdata);
                    end
                    if (m_tuser !== want.format_error)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("%0t: format_error expected %b actual %b",
                                     $time, want.format_error, m_tuser);
                    end
                end
            end

            if (out_calm != 0)
                out_calm--;
            else if (!no_idle && $urandom_range(0, 59) == 0)
                out_calm = $urandom_range(20, 120);

            // one long hold so the pipe fills and s_tready drops
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (out_gap != 0)
            begin
                out_gap--;
                m_tready <= 1'b0;
            end
            else if (!no_idle && out_calm == 0 && $urandom_range(0, 6) == 0)
            begin
                out_gap = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends a run that stops moving
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("msgpack_object_framer_tb failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // opening directed bytes at the reset group size
        foreach (OPENING[i])
            send(OPENING[i]);
        drain();

        set_group('0);              // zero behaves as one
        queue_random(100);
        drain();

        set_group(16'd3);           // long receiver hold lands in this phase
        queue_random(140);
        drain();

        set_group(16'hffff);        // groups never close; running count only
        queue_random(100);
        drain();

        set_group(16'd2);           // lowered below the objects already done
        queue_random(100);
        drain();

        set_group(CFG_W'($urandom_range(1, 9)));
        queue_random(130);
        drain();

        // map32 headers with the largest count drive the owed counter into
        // saturation; the unused code then clears it
        set_group(16'd1);
        repeat (130)
        begin
            send(FMT_MAP32);
            repeat (4) send(8'hff);
        end
        repeat (4) send(8'($urandom_range(0, POSFIX_MAX)));
        send(FMT_UNUSED);
        queue_random(30);
        drain();

        // closing phase at full rate on both sides
        no_idle = 1'b1;
        set_group(16'd5);
        queue_random(130);
        drain();

        if (group_results.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d predicted beats never arrived", $time, group_results.size());
        end

        $display("Framed %0d bytes over %0d group size writes: %0d group ends, %0d format errors.",
                 bytes_sent, cfg_writes, groups_seen, errors_seen);
        $display("Owed counter saturated %0d times; one %0d-cycle output hold; %0d mismatches.",
                 owed_sat_hits, HOLD_CYCLES, mismatches);
        if (mismatches == 0)
            $display("msgpack_object_framer_tb passed");
        else
            $display("msgpack_object_framer_tb failed");
        $finish;
    end

endmodule

### sim.f
src/mof_pkg.sv
src/mof_hdr_dec.sv
src/mof_core.sv
src/msgpack_object_framer.sv
tb/msgpack_object_framer_tb.sv
